### src/seven_segment_scan_driver_assert.svh
// Assertion macros shared by the checkers of the seven-segment scan driver.
// Needs nothing else; take it in by `include where assertions are written.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define SSD_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define SSD_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define SSD_ASSERT_ALWAYS_NEXT(label, clk, lhs, rhs, msg) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

### src/ssd_pkg.sv
// Shared types, constants and the glyph table of the seven-segment scan driver.
// Depends on nothing; the design files and the checker refer to it by scoped names.
package ssd_pkg;

  localparam int DIGITS      = 8;
  localparam int SCAN_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 4;
  localparam int CODE_W      = 5;
  localparam int NUM_W       = 32;
  localparam int LEN_W       = 4;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int EN_W        = 8;
  localparam int SEG_W       = 8;
  localparam int CONV_CNT_W  = $clog2(NUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CODE_W-1:0] BLANK_INDEX = CODE_W'(10);
  localparam logic [SEG_W-1:0]  SEG_DARK    = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_SET_CODE   = 3'd1,
    CMD_SET_DIGIT  = 3'd2,
    CMD_SET_NUMBER = 3'd3,
    CMD_SCAN_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_WRITE,
    OP_NUMBER,
    OP_SCAN
  } op_kind_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    op_kind_t             kind;
    logic [POS_W-1:0]     position;
    logic [CODE_W-1:0]    glyph;
    logic [NUM_W-1:0]     number;
    logic [LEN_W-1:0]     length;
    logic                 lead;
  } op_t;

  // Active-low segment pattern of a glyph index; bit 7 is the decimal point.
  function automatic logic [SEG_W-1:0] glyph_pattern(input logic [CODE_W-1:0] idx);
    logic [SEG_W-1:0] seg;
    unique case (idx)
      5'd0:    seg = 8'hC0;
      5'd1:    seg = 8'hF9;
      5'd2:    seg = 8'hA4;
      5'd3:    seg = 8'hB0;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h92;
      5'd6:    seg = 8'h82;
      5'd7:    seg = 8'hF8;
      5'd8:    seg = 8'h80;
      5'd9:    seg = 8'h90;
      5'd10:   seg = 8'hFF;
      5'd11:   seg = 8'hBF;
      5'd12:   seg = 8'hC1;
      5'd13:   seg = 8'h89;
      5'd14:   seg = 8'hC8;
      5'd15:   seg = 8'h8C;
      5'd16:   seg = 8'hC6;
      5'd17:   seg = 8'h88;
      5'd18:   seg = 8'hC0;
      5'd19:   seg = 8'hAF;
      5'd20:   seg = 8'h7F;
      default: seg = SEG_DARK;
    endcase
    return seg;
  endfunction

endpackage

### src/ssd_front.sv
// Front end: takes commands and classifies them into queue entries.
// Depends on ssd_pkg.
module ssd_front (
  input  logic                         start,
  input  logic [ssd_pkg::CMD_W-1:0]    command,
  input  logic [ssd_pkg::POS_W-1:0]    position,
  input  logic [ssd_pkg::CODE_W-1:0]   code,
  input  logic [ssd_pkg::NUM_W-1:0]    number,
  input  logic [ssd_pkg::LEN_W-1:0]    length,
  input  logic                         blank_zeros,
  input  logic                         full,
  output logic                         busy,
  output logic                         push,
  output ssd_pkg::op_t                 op
);

  logic accept;
  logic known;

  assign busy   = full;
  assign accept = start && !full;
  assign push   = accept && known;

  always_comb begin
    op.kind     = ssd_pkg::OP_SCAN;
    op.position = position;
    op.glyph    = code;
    op.number   = number;
    op.lead     = blank_zeros;
    // clamp the conversion length to the display width
    op.length   = (length > ssd_pkg::LEN_W'(ssd_pkg::DIGITS)) ?
                  ssd_pkg::LEN_W'(ssd_pkg::DIGITS) : length;
    known       = 1'b1;
    unique case (command)
      ssd_pkg::CMD_CLEAR:      op.kind = ssd_pkg::OP_CLEAR;
      ssd_pkg::CMD_SET_CODE:   op.kind = ssd_pkg::OP_WRITE;
      ssd_pkg::CMD_SET_DIGIT: begin
        op.kind  = ssd_pkg::OP_WRITE;
        op.glyph = (number > ssd_pkg::NUM_W'(9)) ? ssd_pkg::BLANK_INDEX :
                   number[ssd_pkg::CODE_W-1:0];
      end
      ssd_pkg::CMD_SET_NUMBER: op.kind = ssd_pkg::OP_NUMBER;
      ssd_pkg::CMD_SCAN_TICK:  op.kind = ssd_pkg::OP_SCAN;
      default:                 known   = 1'b0;  // drop unused codes
    endcase
  end

endmodule

### src/ssd_queue.sv
// Short in-order queue between front and back ends.
// Depends on ssd_pkg.
module ssd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssd_pkg::op_t  push_op,
  input  logic          pop,
  output ssd_pkg::op_t  head,
  output logic          full,
  output logic          empty
);

  ssd_pkg::op_t               entries [ssd_pkg::QUEUE_DEPTH];
  logic [ssd_pkg::QPTR_W-1:0] wr_ptr;
  logic [ssd_pkg::QPTR_W-1:0] rd_ptr;
  logic [ssd_pkg::QPTR_W:0]   count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (ssd_pkg::QPTR_W + 1)'(ssd_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

### src/ssd_back.sv
// Back end: display buffer, scan pointer and the serial number conversion.
// Depends on ssd_pkg.
module ssd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  ssd_pkg::op_t                head,
  output logic                        pop,
  output logic                        strobe,
  output logic [ssd_pkg::EN_W-1:0]    digit_enable,
  output logic [ssd_pkg::SEG_W-1:0]   segments
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_WRITE
  } state_t;

  state_t                          state;
  ssd_pkg::op_t                    cur;
  logic [ssd_pkg::CODE_W-1:0]      buffer [ssd_pkg::DIGITS];
  logic [ssd_pkg::SCAN_W-1:0]      scan_pos;
  logic [ssd_pkg::NUM_W-1:0]       bin;
  logic [ssd_pkg::BCD_W-1:0]       bcd;
  logic [ssd_pkg::BCD_W-1:0]       bcd_adj;
  logic [ssd_pkg::CONV_CNT_W-1:0]  conv_cnt;
  logic [ssd_pkg::SCAN_W-1:0]      wr_idx;
  logic                            lead_run;
  logic [ssd_pkg::LEN_W-1:0]       out_off;
  logic [ssd_pkg::POS_W:0]         wr_pos;
  logic [3:0]                      wr_digit;
  logic                            wr_blank;
  logic [ssd_pkg::EN_W-1:0]        en_next;
  logic [ssd_pkg::SCAN_W-1:0]      scan_pos_next;

  assign pop = (state == S_IDLE) && !empty;

  // add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // wr_idx counts BCD digits down from the most significant kept one
  always_comb begin
    out_off  = (cur.length - 1'b1) - ssd_pkg::LEN_W'(wr_idx);
    wr_pos   = {1'b0, cur.position} + (ssd_pkg::POS_W + 1)'(out_off);
    wr_digit = bcd[4*wr_idx +: 4];
    wr_blank = lead_run && (wr_idx != '0) && (wr_digit == 4'd0);
  end

  always_comb begin
    for (int i = 0; i < ssd_pkg::EN_W; i++) begin
      en_next[i] = (i < ssd_pkg::DIGITS) && (scan_pos == ssd_pkg::SCAN_W'(i));
    end
    scan_pos_next = (scan_pos == ssd_pkg::SCAN_W'(ssd_pkg::DIGITS - 1)) ? '0 :
                    scan_pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_pos <= '0;
      strobe   <= 1'b0;
      for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
        buffer[i] <= ssd_pkg::BLANK_INDEX;
      end
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            unique case (head.kind)
              ssd_pkg::OP_CLEAR: begin
                for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
                  buffer[i] <= ssd_pkg::BLANK_INDEX;
                end
              end
              ssd_pkg::OP_WRITE: begin
                if (head.position < ssd_pkg::POS_W'(ssd_pkg::DIGITS)) begin
                  buffer[head.position[ssd_pkg::SCAN_W-1:0]] <= head.glyph;
                end
              end
              ssd_pkg::OP_NUMBER: begin
                cur      <= head;
                bin      <= head.number;
                bcd      <= '0;
                conv_cnt <= '0;
                state    <= S_CONV;
              end
              ssd_pkg::OP_SCAN: begin
                strobe       <= 1'b1;
                digit_enable <= en_next;
                segments     <= ssd_pkg::glyph_pattern(buffer[scan_pos]);
                scan_pos     <= scan_pos_next;
              end
            endcase
          end
        end
        S_CONV: begin
          bcd      <= {bcd_adj[ssd_pkg::BCD_W-2:0], bin[ssd_pkg::NUM_W-1]};
          bin      <= {bin[ssd_pkg::NUM_W-2:0], 1'b0};
          conv_cnt <= conv_cnt + 1'b1;
          if (conv_cnt == ssd_pkg::CONV_CNT_W'(ssd_pkg::NUM_W - 1)) begin
            lead_run <= cur.lead;
            wr_idx   <= ssd_pkg::SCAN_W'(cur.length - 1'b1);
            state    <= (cur.length == '0) ? S_IDLE : S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_pos < (ssd_pkg::POS_W + 1)'(ssd_pkg::DIGITS)) begin
            buffer[wr_pos[ssd_pkg::SCAN_W-1:0]] <= wr_blank ? ssd_pkg::BLANK_INDEX :
                                                   ssd_pkg::CODE_W'(wr_digit);
          end
          if (!wr_blank) begin
            lead_run <= 1'b0;
          end
          if (wr_idx == '0) begin
            state <= S_IDLE;
          end else begin
            wr_idx <= wr_idx - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/seven_segment_scan_driver.sv
// Top level of the eight-digit multiplexed seven-segment scan driver.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.

// An item is taken at a clock edge with start high and busy low; busy rises only
// while the two-entry command queue is full. Clear, set_code, set_digit and
// scan_tick are each carried out as the back end takes them from the queue;
// set_number holds the back end for 32 double-dabble shift steps, then one
// buffer write per kept digit, the length being clamped to eight. A
// scan_tick result appears on digit_enable and segments with strobe high for
// exactly one cycle, in the cycle after the back end takes it from the queue; the
// receiver cannot hold it off, so sample it on that cycle. Items are carried out
// strictly in order, so a scan tick always sees every earlier write. Reset
// blanks the whole buffer and points the scan at digit zero.
module seven_segment_scan_driver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssd_pkg::CMD_W-1:0]     command,
  input  logic [ssd_pkg::POS_W-1:0]     position,
  input  logic [ssd_pkg::CODE_W-1:0]    code,
  input  logic [ssd_pkg::NUM_W-1:0]     number,
  input  logic [ssd_pkg::LEN_W-1:0]     length,
  input  logic                          blank_zeros,
  output logic                          strobe,
  output logic [ssd_pkg::EN_W-1:0]      digit_enable,
  output logic [ssd_pkg::SEG_W-1:0]     segments
);

  // front to queue
  logic          push;
  ssd_pkg::op_t  push_op;
  // queue to back
  logic          full;
  logic          empty;
  logic          pop;
  ssd_pkg::op_t  head;

  // classify the item; drop unused command codes here
  ssd_front u_front (
    .start         (start),
    .command       (command),
    .position      (position),
    .code          (code),
    .number        (number),
    .length        (length),
    .blank_zeros   (blank_zeros),
    .full          (full),
    .busy          (busy),
    .push          (push),
    .op            (push_op)
  );

  // hold items while the back end is converting a number and writing its digits
  ssd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  // carry out buffer writes, conversions and scan ticks
  ssd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .digit_enable (digit_enable),
    .segments     (segments)
  );

endmodule

### src/ssd_checker.sv
// Port-level checker of the seven-segment scan driver, bound to the top level.
// Depends on ssd_pkg and seven_segment_scan_driver_assert.svh.
`include "seven_segment_scan_driver_assert.svh"

module ssd_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         strobe,
  input  logic [ssd_pkg::EN_W-1:0]     digit_enable
);

  logic [ssd_pkg::EN_W-1:0] last_en;
  logic                     seen;
  logic [ssd_pkg::EN_W-1:0] expect_en;

  // after reset the scan starts at digit zero, then steps up by one per result
  assign expect_en = seen ? {last_en[ssd_pkg::EN_W-2:0], last_en[ssd_pkg::EN_W-1]} :
                     ssd_pkg::EN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= 1'b0;
      last_en <= '0;
    end else if (strobe) begin
      seen    <= 1'b1;
      last_en <= digit_enable;
    end
  end

  `SSD_ASSERT_NOW(a_one_hot, clk, rst, strobe, $onehot(digit_enable), "digit select not one-hot")
  `SSD_ASSERT_NOW(a_scan_order, clk, rst, strobe, digit_enable == expect_en, "scan order broken")
  `SSD_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !strobe, "result strobe right after reset")

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
  .clk          (clk),
  .rst          (rst),
  .strobe       (strobe),
  .digit_enable (digit_enable)
);
